### sv/lpw_pkg.sv
`timescale 1ns / 1ps

package lpw_pkg;

  localparam int PANEL_WIDTH_DEF  = 128;
  localparam int PANEL_HEIGHT_DEF = 128;

  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 40;

  localparam logic OP_WINDOW = 1'b0;
  localparam logic OP_PIXEL  = 1'b1;

  localparam logic [1:0] ORIENT_NORMAL  = 2'd0;
  localparam logic [1:0] ORIENT_FLIPPED = 2'd1;
  localparam logic [1:0] ORIENT_ROTATED = 2'd2;

  // One classified command as it waits between the front and the back.
  typedef struct packed {
    logic        is_pixel;
    logic [7:0]  left;
    logic [7:0]  top;
    logic [7:0]  right;
    logic [7:0]  bottom;
    logic [15:0] pixel;
  } q_item_t;

endpackage

### sv/lpw_front.sv
`timescale 1ns / 1ps

module lpw_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [lpw_pkg::S_DATA_W-1:0]    s_tdata,
  input  logic                            s_tuser,
  output logic                            push,
  input  logic                            q_full,
  output lpw_pkg::q_item_t                item
);

  logic             valid;
  lpw_pkg::q_item_t item_next;

  assign push     = valid && !q_full;
  assign s_tready = !valid || !q_full;

  // The right and bottom edges are formed here so the back only compares.
  always_comb begin
    item_next.is_pixel = (s_tuser == lpw_pkg::OP_PIXEL);
    item_next.left     = s_tdata[7:0];
    item_next.top      = s_tdata[15:8];
    item_next.right    = s_tdata[7:0] + s_tdata[23:16];
    item_next.bottom   = s_tdata[15:8] + s_tdata[31:24];
    item_next.pixel    = s_tdata[47:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

### sv/lpw_queue.sv
`timescale 1ns / 1ps

module lpw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lpw_pkg::q_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output lpw_pkg::q_item_t pop_item
);

  lpw_pkg::q_item_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign q_valid  = (count != 2'd0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

### sv/lpw_back.sv
`timescale 1ns / 1ps

module lpw_back #(
  parameter int PANEL_WIDTH  = lpw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lpw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,
  input  logic                         q_valid,
  input  lpw_pkg::q_item_t             item,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [lpw_pkg::M_DATA_W-1:0] m_tdata
);

  localparam logic [9:0] PANEL_W = 10'(PANEL_WIDTH);
  localparam logic [9:0] PANEL_H = 10'(PANEL_HEIGHT);

  logic [1:0]        orient;
  logic [7:0]        left_edge;
  logic [7:0]        top_edge;
  logic [7:0]        right_edge;
  logic [7:0]        bottom_edge;
  logic signed [9:0] cursor_col;
  logic signed [9:0] cursor_row;

  logic signed [9:0] cursor_col_next;
  logic signed [9:0] cursor_row_next;
  logic signed [9:0] lft;
  logic signed [9:0] tp;
  logic signed [9:0] rgt;
  logic signed [9:0] bot;
  logic              in_win;
  logic              in_panel;
  logic              emit;
  logic              out_free;

  assign lft = signed'({2'b00, left_edge});
  assign tp  = signed'({2'b00, top_edge});
  assign rgt = signed'({2'b00, right_edge});
  assign bot = signed'({2'b00, bottom_edge});

  assign in_win   = (cursor_col >= lft) && (cursor_col <= rgt) &&
                    (cursor_row >= tp) && (cursor_row <= bot);
  // Inside the window both coordinates are non-negative.
  assign in_panel = ($unsigned(cursor_col) < PANEL_W) && ($unsigned(cursor_row) < PANEL_H);
  assign emit     = item.is_pixel && in_win && in_panel;
  assign out_free = !m_tvalid || m_tready;
  assign pop      = q_valid && (!emit || out_free);

  always_comb begin
    cursor_col_next = cursor_col;
    cursor_row_next = cursor_row;
    case (orient)
      lpw_pkg::ORIENT_ROTATED: begin
        cursor_row_next = cursor_row - 10'sd1;
        if (cursor_row_next < tp) begin
          cursor_row_next = bot;
          cursor_col_next = cursor_col + 10'sd1;
        end
      end
      lpw_pkg::ORIENT_FLIPPED: begin
        cursor_col_next = cursor_col - 10'sd1;
        if (cursor_col_next < lft) begin
          cursor_col_next = rgt;
          cursor_row_next = cursor_row - 10'sd1;
        end
      end
      default: begin
        cursor_col_next = cursor_col + 10'sd1;
        if (cursor_col_next > rgt) begin
          cursor_col_next = lft;
          cursor_row_next = cursor_row + 10'sd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orient      <= lpw_pkg::ORIENT_NORMAL;
      left_edge   <= '0;
      top_edge    <= '0;
      right_edge  <= '0;
      bottom_edge <= '0;
      cursor_col  <= '0;
      cursor_row  <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        orient <= cfg_wdata;
      end
      if (pop && !item.is_pixel) begin
        left_edge   <= item.left;
        top_edge    <= item.top;
        right_edge  <= item.right;
        bottom_edge <= item.bottom;
        case (orient)
          lpw_pkg::ORIENT_ROTATED: begin
            cursor_col <= signed'({2'b00, item.left});
            cursor_row <= signed'({2'b00, item.bottom});
          end
          lpw_pkg::ORIENT_FLIPPED: begin
            cursor_col <= signed'({2'b00, item.right});
            cursor_row <= signed'({2'b00, item.bottom});
          end
          default: begin
            cursor_col <= signed'({2'b00, item.left});
            cursor_row <= signed'({2'b00, item.top});
          end
        endcase
      end else if (pop && emit) begin
        cursor_col <= cursor_col_next;
        cursor_row <= cursor_row_next;
      end
      if (pop && emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      m_tdata <= {item.pixel[4:0], 3'b000,
                  item.pixel[10:5], 2'b00,
                  item.pixel[15:11], 3'b000,
                  cursor_row[7:0],
                  cursor_col[7:0]};
    end
  end

endmodule

### sv/lcd_window_pixel_writer.sv
`timescale 1ns / 1ps

// Window pixel writer: a set-window transaction (tuser 0) loads a rectangle and puts the
// cursor at the start corner for the scan orientation; each pixel transaction (tuser 1)
// yields one frame-store write at the cursor with the RGB565 color widened to 8 bits per
// channel, then moves the cursor in scan order. Pixels whose cursor falls outside the
// window or the panel produce no output and leave the cursor where it is. One transaction
// is accepted per clock in steady state while the output does not stall; the cursor
// update in the back stage is the loop that sets this rate. An accepted pixel loads the
// input register, then moves into the two-entry queue, and from there into the output
// register, after which its write is shown on the master side. The user must write the
// orientation register only while the block is idle; the block does not enforce this.
module lcd_window_pixel_writer #(
  parameter int PANEL_WIDTH  = lpw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lpw_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_wdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // win_x[7:0], win_y[15:8], win_width[23:16], win_height[31:24], pixel_rgb565[47:32]
  input  logic [lpw_pkg::S_DATA_W-1:0] s_tdata,
  // opcode[0]
  input  logic                         s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // column[7:0], row[15:8], red8[23:16], green8[31:24], blue8[39:32]
  output logic [lpw_pkg::M_DATA_W-1:0] m_tdata
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  lpw_pkg::q_item_t front_item;
  lpw_pkg::q_item_t back_item;

  lpw_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .q_full   (q_full),
    .item     (front_item)
  );

  lpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_item  (back_item)
  );

  lpw_back #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .item      (back_item),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### sv/lpw_chk.sv
`timescale 1ns / 1ps

module lpw_chk #(
  parameter int PANEL_WIDTH  = lpw_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lpw_pkg::PANEL_HEIGHT_DEF
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         cfg_we,
  input logic [1:0]                   cfg_wdata,
  input logic                         s_tvalid,
  input logic                         s_tready,
  input logic [lpw_pkg::S_DATA_W-1:0] s_tdata,
  input logic                         s_tuser,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [lpw_pkg::M_DATA_W-1:0] m_tdata
);

  localparam logic [8:0] PANEL_W = 9'(PANEL_WIDTH);
  localparam logic [8:0] PANEL_H = 9'(PANEL_HEIGHT);

  // The pipeline is empty after reset, so the slave side is open and nothing is shown.
  a_reset_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  a_in_panel: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({1'b0, m_tdata[7:0]} < PANEL_W) && ({1'b0, m_tdata[15:8]} < PANEL_H))
    else $error("write address outside the panel");

  a_low_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:16] == 3'b000) && (m_tdata[25:24] == 2'b00) &&
                 (m_tdata[34:32] == 3'b000))
    else $error("color low bits not zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output transaction changed");

endmodule

bind lcd_window_pixel_writer lpw_chk #(
  .PANEL_WIDTH  (PANEL_WIDTH),
  .PANEL_HEIGHT (PANEL_HEIGHT)
) u_lpw_chk (.*);

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] ORIENT_UNUSED = 2'd3;
  localparam int PANEL_W = lpw_pkg::PANEL_WIDTH_DEF;
  localparam int PANEL_H = lpw_pkg::PANEL_HEIGHT_DEF;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int ITEMS_PER_PHASE = 110;

  typedef struct {
    logic        opcode;
    bit   [7:0]  x;
    bit   [7:0]  y;
    bit   [7:0]  w;
    bit   [7:0]  h;
    bit   [15:0] rgb;
  } host_cmd_t;

  typedef struct {
    bit [7:0] column;
    bit [7:0] row;
    bit [7:0] red8;
    bit [7:0] green8;
    bit [7:0] blue8;
  } fb_write_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_we = 1'b0;
  logic [1:0]                   cfg_wdata = 2'd0;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [lpw_pkg::S_DATA_W-1:0] s_tdata = '0;
  logic                         s_tuser = 1'b0;
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [lpw_pkg::M_DATA_W-1:0] m_tdata;

  lcd_window_pixel_writer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Local copy of the window engine state.
  logic [1:0]        scan_orient = lpw_pkg::ORIENT_NORMAL;
  bit [7:0]          win_left, win_top, win_right, win_bottom;
  logic signed [9:0] cur_col, cur_row;

  host_cmd_t cmds_pending[$];
  host_cmd_t cmd_on_bus;
  fb_write_t writes_due[$];
  int        error_count = 0;
  bit        cmd_taken = 1'b0;
  bit        wr_taken = 1'b0;

  function automatic void run_window_engine(host_cmd_t c);
    int col, row, l, t, r, b;
    fb_write_t wr;
    if (c.opcode == lpw_pkg::OP_WINDOW) begin
      win_left   = c.x;
      win_top    = c.y;
      win_right  = c.x + c.w;
      win_bottom = c.y + c.h;
      case (scan_orient)
        lpw_pkg::ORIENT_ROTATED: begin
          cur_col = {2'b00, win_left};
          cur_row = {2'b00, win_bottom};
        end
        lpw_pkg::ORIENT_FLIPPED: begin
          cur_col = {2'b00, win_right};
          cur_row = {2'b00, win_bottom};
        end
        default: begin
          cur_col = {2'b00, win_left};
          cur_row = {2'b00, win_top};
        end
      endcase
      return;
    end
    col = int'(cur_col);
    row = int'(cur_row);
    l = int'(win_left);
    t = int'(win_top);
    r = int'(win_right);
    b = int'(win_bottom);
    // Outside the window or the panel: no write, and the cursor stays put.
    if (col < l || col > r || row < t || row > b) return;
    if (col >= PANEL_W || row >= PANEL_H) return;
    wr.column = col[7:0];
    wr.row    = row[7:0];
    wr.red8   = {c.rgb[15:11], 3'b000};
    wr.green8 = {c.rgb[10:5], 2'b00};
    wr.blue8  = {c.rgb[4:0], 3'b000};
    writes_due.push_back(wr);
    case (scan_orient)
      lpw_pkg::ORIENT_ROTATED: begin
        row = row - 1;
        if (row < t) begin
          row = b;
          col = col + 1;
        end
      end
      lpw_pkg::ORIENT_FLIPPED: begin
        col = col - 1;
        if (col < l) begin
          col = r;
          row = row - 1;
        end
      end
      default: begin
        col = col + 1;
        if (col > r) begin
          col = l;
          row = row + 1;
        end
      end
    endcase
    cur_col = col[9:0];
    cur_row = row[9:0];
  endfunction

  function automatic host_cmd_t window_cmd(bit [7:0] x, bit [7:0] y, bit [7:0] w, bit [7:0] h);
    host_cmd_t c;
    c.opcode = lpw_pkg::OP_WINDOW;
    c.x = x;
    c.y = y;
    c.w = w;
    c.h = h;
    c.rgb = 16'($urandom());
    return c;
  endfunction

  function automatic host_cmd_t pixel_cmd(bit [15:0] rgb);
    host_cmd_t c;
    c.opcode = lpw_pkg::OP_PIXEL;
    c.x = 8'($urandom());
    c.y = 8'($urandom());
    c.w = 8'($urandom());
    c.h = 8'($urandom());
    c.rgb = rgb;
    return c;
  endfunction

  function automatic bit [7:0] pick_corner();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 7));
      1: return 8'($urandom_range(120, 127));
      2: return 8'($urandom_range(0, 127));
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic push_pixels(int n);
    repeat (n) cmds_pending.push_back(pixel_cmd(16'($urandom())));
  endtask

  // Mostly well-formed window-then-fill sequences, with some noise in between.
  task automatic fill_phase(int n_items);
    int start, w, h, area;
    start = cmds_pending.size();
    // Leftover cursor from the last phase now moves under the new orientation.
    if ($urandom_range(0, 3) == 0) push_pixels(int'($urandom_range(1, 4)));
    while (cmds_pending.size() - start < n_items) begin
      case ($urandom_range(0, 9))
        0: begin
          cmds_pending.push_back(window_cmd(8'($urandom()), 8'($urandom()),
                                            8'($urandom()), 8'($urandom())));
          push_pixels(int'($urandom_range(0, 4)));
        end
        1: push_pixels(int'($urandom_range(1, 5)));
        default: begin
          w = int'($urandom_range(0, 7));
          h = int'($urandom_range(0, 5));
          area = (w + 1) * (h + 1);
          cmds_pending.push_back(window_cmd(pick_corner(), pick_corner(), 8'(w), 8'(h)));
          push_pixels(area - 1 + int'($urandom_range(0, 3)));
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    while (cmds_pending.size() != 0 || s_tvalid || writes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_orientation(logic [1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    scan_orient = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Input side: accept at the rising edge, drive at the falling edge.
  int  in_gap = 0;
  bit  in_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      run_window_engine(cmd_on_bus);
      cmd_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    logic nv;
    nv = s_tvalid;
    if (rst) begin
      nv = 1'b0;
    end else begin
      if (cmd_taken) begin
        nv = 1'b0;
        cmd_taken = 1'b0;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (cmds_pending.size() != 0) begin
          cmd_on_bus = cmds_pending.pop_front();
          s_tdata <= {cmd_on_bus.rgb, cmd_on_bus.h, cmd_on_bus.w, cmd_on_bus.y, cmd_on_bus.x};
          s_tuser <= cmd_on_bus.opcode;
          nv = 1'b1;
          if ($urandom_range(0, 19) == 0) in_burst = !in_burst;
          in_gap = in_burst ? 0 : int'($urandom_range(0, 15));
        end
      end
    end
    s_tvalid <= nv;
  end

  // Output side.
  int out_stall = 0;
  bit out_burst = 1'b0;

  function automatic void check_field(string name, bit [7:0] exp_v, bit [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    fb_write_t exp_wr;
    if (!rst && m_tvalid && m_tready) begin
      wr_taken = 1'b1;
      if (writes_due.size() == 0) begin
        $error("unexpected frame-store write, tdata %h", m_tdata);
        error_count++;
      end else begin
        exp_wr = writes_due.pop_front();
        check_field("column", exp_wr.column, m_tdata[7:0]);
        check_field("row", exp_wr.row, m_tdata[15:8]);
        check_field("red8", exp_wr.red8, m_tdata[23:16]);
        check_field("green8", exp_wr.green8, m_tdata[31:24]);
        check_field("blue8", exp_wr.blue8, m_tdata[39:32]);
      end
    end
  end

  always @(negedge clk) begin
    if (wr_taken) begin
      wr_taken = 1'b0;
      if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
      out_stall = out_burst ? 0 : int'($urandom_range(0, 15));
    end
    if (out_stall > 0) begin
      out_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction.
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0] phase_orients[6];
    phase_orients = '{lpw_pkg::ORIENT_FLIPPED, lpw_pkg::ORIENT_ROTATED, ORIENT_UNUSED,
                      lpw_pkg::ORIENT_NORMAL, lpw_pkg::ORIENT_ROTATED,
                      lpw_pkg::ORIENT_FLIPPED};
    win_left = '0;
    win_top = '0;
    win_right = '0;
    win_bottom = '0;
    cur_col = '0;
    cur_row = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Pixel before any window: the reset window holds only the origin.
    cmds_pending.push_back(pixel_cmd(16'h1234));
    // A 3x2 window filled past its last pixel, with color extremes.
    cmds_pending.push_back(window_cmd(8'd0, 8'd0, 8'd2, 8'd1));
    cmds_pending.push_back(pixel_cmd(16'hFFFF));
    cmds_pending.push_back(pixel_cmd(16'h0000));
    cmds_pending.push_back(pixel_cmd(16'hF800));
    cmds_pending.push_back(pixel_cmd(16'h07E0));
    cmds_pending.push_back(pixel_cmd(16'h001F));
    cmds_pending.push_back(pixel_cmd(16'hAAAA));
    cmds_pending.push_back(pixel_cmd(16'h5555));
    // Window crossing the right panel edge: the cursor stops at the panel.
    cmds_pending.push_back(window_cmd(8'd126, 8'd127, 8'd5, 8'd0));
    cmds_pending.push_back(pixel_cmd(16'h8421));
    cmds_pending.push_back(pixel_cmd(16'h7BDE));
    cmds_pending.push_back(pixel_cmd(16'hFFFF));
    cmds_pending.push_back(pixel_cmd(16'h0001));
    // Right edge wraps below the left corner: empty window.
    cmds_pending.push_back(window_cmd(8'd250, 8'd10, 8'd10, 8'd0));
    cmds_pending.push_back(pixel_cmd(16'hFFFF));
    // All window fields at their maximum: both edges wrap.
    cmds_pending.push_back(window_cmd(8'hFF, 8'hFF, 8'hFF, 8'hFF));
    cmds_pending.push_back(pixel_cmd(16'hFFFF));
    // Window completely outside the panel.
    cmds_pending.push_back(window_cmd(8'd200, 8'd5, 8'd3, 8'd0));
    cmds_pending.push_back(pixel_cmd(16'h0F0F));
    // Window at the far panel corner, fill plus one extra.
    cmds_pending.push_back(window_cmd(8'd127, 8'd127, 8'd0, 8'd0));
    cmds_pending.push_back(pixel_cmd(16'hF0F0));
    cmds_pending.push_back(pixel_cmd(16'h3C3C));
    wait_drained();

    foreach (phase_orients[i]) begin
      write_orientation(phase_orients[i]);
      fill_phase(ITEMS_PER_PHASE);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
